[hw/rtl/ffv_pkg.sv]
// ----------------------------------------------------------------------------
// ffv_pkg: shared constants and types for the floc viscosity block
// Register indexes, reset values and the 2^(2^-i) root table used by exp2.
// ----------------------------------------------------------------------------
package ffv_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // long divider: one setup stage plus one stage per quotient bit
  localparam int DIV_LAT = 33;

  localparam logic [16:0] MARGIN_FRAC = 17'd655;    // 0.01 in Q0.16
  localparam logic [16:0] FLOOR_FRAC  = 17'd19661;  // 0.3 in Q0.16

  localparam logic [31:0] QMAX = 32'hFFFF_FFFF;

  localparam logic [31:0] RST_FLUID_VISC  = 32'd65536;
  localparam logic [15:0] RST_MAX_FRAC    = 16'd39322;
  localparam logic [31:0] RST_STRAIN_EXP  = 32'd65536;
  localparam logic [31:0] RST_YIELD       = 32'd65536;
  localparam logic [31:0] RST_FRACTAL_EXP = 32'd131072;
  localparam logic [31:0] RST_CAP         = 32'hFFFF_FFFF;
  localparam logic [31:0] RST_BETA        = 32'd65536;

  typedef enum logic [2:0] {
    CFG_FLUID_VISC  = 3'd0,
    CFG_MAX_FRAC    = 3'd1,
    CFG_STRAIN_EXP  = 3'd2,
    CFG_YIELD       = 3'd3,
    CFG_FRACTAL_EXP = 3'd4,
    CFG_CAP         = 3'd5,
    CFG_BETA        = 3'd6
  } cfg_idx_e;

  // integer square root, elaboration use only
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bm;
    rem = v;
    res = '0;
    bm  = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (bm > rem) bm = bm >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (bm != 0) begin
        if (rem >= res + bm) begin
          rem = rem - (res + bm);
          res = (res >> 1) + bm;
        end else begin
          res = res >> 1;
        end
        bm = bm >> 2;
      end
    end
    return res;
  endfunction

  // 2^(2^-i) in Q1.31, i from 1
  function automatic logic [31:0] root_const(input int i);
    logic [63:0] c;
    c = isqrt64(64'h8000_0000_0000_0000);
    for (int j = 2; j <= 24; j++) begin
      if (j <= i) c = isqrt64(c << 31);
    end
    return c[31:0];
  endfunction

endpackage

[hw/rtl/ffv_dly.sv]
// ----------------------------------------------------------------------------
// ffv_dly: enabled delay line
// Aligns an operand with a later stage of the pipeline.
// ----------------------------------------------------------------------------
module ffv_dly #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

[hw/rtl/ffv_div.sv]
// ----------------------------------------------------------------------------
// ffv_div: pipelined fixed-point divider
// q = (a << FRAC_BITS) / b, saturated; one quotient bit per stage.
// ----------------------------------------------------------------------------
module ffv_div #(
  parameter int FRAC_BITS = ffv_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] q_o
);

  localparam int NIT = ffv_pkg::DIV_LAT - 1;

  logic [31:0] rem_q  [NIT+1];
  logic [31:0] low_q  [NIT+1];
  logic [31:0] quo_q  [NIT+1];
  logic [31:0] dvs_q  [NIT+1];
  logic        sat_q  [NIT+1];
  logic        zero_q [NIT+1];

  logic [31:0] top_part;
  assign top_part = a_i >> (32 - FRAC_BITS);

  // setup: the high dividend part gives the overflow test and the first remainder
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= top_part;
      low_q[0]  <= a_i << FRAC_BITS;
      quo_q[0]  <= '0;
      dvs_q[0]  <= b_i;
      sat_q[0]  <= (b_i == '0) ? (a_i != '0) : (top_part >= b_i);
      zero_q[0] <= (b_i == '0) && (a_i == '0);
    end
  end

  for (genvar g = 1; g <= NIT; g++) begin : g_it
    logic [32:0] trial;
    logic        fits;
    assign trial = {rem_q[g-1], low_q[g-1][31]};
    assign fits  = trial >= {1'b0, dvs_q[g-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= fits ? 32'(trial - {1'b0, dvs_q[g-1]}) : trial[31:0];
        low_q[g]  <= low_q[g-1] << 1;
        quo_q[g]  <= {quo_q[g-1][30:0], fits};
        dvs_q[g]  <= dvs_q[g-1];
        sat_q[g]  <= sat_q[g-1];
        zero_q[g] <= zero_q[g-1];
      end
    end
  end

  assign q_o = sat_q[NIT] ? ffv_pkg::QMAX : (zero_q[NIT] ? '0 : quo_q[NIT]);

endmodule

[hw/rtl/ffv_pow.sv]
// ----------------------------------------------------------------------------
// ffv_pow: pipelined fixed-point power x^y = exp2(floor(log2(x) * y))
// Log by repeated squaring, exp2 by a chain of root multiplies.
// ----------------------------------------------------------------------------
module ffv_pow #(
  parameter int FRAC_BITS = ffv_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  output logic [31:0] p_o
);

  localparam int FB  = FRAC_BITS;
  localparam int LW  = FB + 6;
  localparam int MW  = LW + 33;
  localparam int NFL = 2 * FB + 3;
  localparam logic [31:0]          ONE   = 32'(1 << FB);
  localparam logic signed [MW-1:0] SAT_T = MW'((32 - FB) * (1 << FB));
  localparam logic signed [MW-1:0] SH0   = MW'(31 - FB);

  logic [NFL-1:0] xz_q;
  logic [NFL-1:0] yz_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xz_q <= {xz_q[NFL-2:0], x_i == '0};
      yz_q <= {yz_q[NFL-2:0], y_i == '0};
    end
  end

  // normalize
  logic [4:0] lead;
  always_comb begin
    lead = '0;
    for (int k = 0; k < 32; k++) begin
      if (x_i[k]) lead = 5'(k);
    end
  end

  logic [31:0]   z_q    [FB+1];
  logic [FB-1:0] frac_q [FB+1];
  logic [4:0]    lp_q   [FB+1];
  logic [31:0]   ly_q   [FB+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0]    <= x_i << (5'd31 - lead);
      frac_q[0] <= '0;
      lp_q[0]   <= lead;
      ly_q[0]   <= y_i;
    end
  end

  for (genvar g = 1; g <= FB; g++) begin : g_log
    logic [63:0] sq;
    logic [32:0] sh;
    assign sq = 64'(z_q[g-1]) * 64'(z_q[g-1]);
    assign sh = sq[63:31];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[g]    <= sh[32] ? sh[32:1] : sh[31:0];
        frac_q[g] <= frac_q[g-1] | (sh[32] ? FB'(1) << (FB - g) : '0);
        lp_q[g]   <= lp_q[g-1];
        ly_q[g]   <= ly_q[g-1];
      end
    end
  end

  // scale the log by the exponent
  logic [LW-1:0]        lg;
  logic signed [MW-1:0] prod_q;
  assign lg = {6'({1'b0, lp_q[FB]}) - 6'(FB), frac_q[FB]};

  always_ff @(posedge clk_i) begin
    if (en_i) prod_q <= $signed(lg) * $signed({1'b0, ly_q[FB]});
  end

  // floor, split into integer and fraction, find the final shift
  logic signed [MW-1:0] ts;
  logic signed [MW-1:0] kk;
  logic signed [MW-1:0] shv;
  assign ts  = prod_q >>> FB;
  assign kk  = ts >>> FB;
  assign shv = SH0 - kk;

  logic [31:0]   mm_q  [FB+1];
  logic [FB-1:0] f_q   [FB+1];
  logic          sat_q [FB+1];
  logic          shz_q [FB+1];
  logic [4:0]    sh_q  [FB+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mm_q[0]  <= 32'h8000_0000;
      f_q[0]   <= ts[FB-1:0];
      sat_q[0] <= ts >= SAT_T;
      shz_q[0] <= shv >= MW'(32);
      sh_q[0]  <= shv[4:0];
    end
  end

  for (genvar g = 1; g <= FB; g++) begin : g_exp
    localparam logic [31:0] ROOT = ffv_pkg::root_const(g);
    logic [63:0] pr;
    assign pr = 64'(mm_q[g-1]) * 64'(ROOT);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mm_q[g]  <= f_q[g-1][FB-g] ? pr[62:31] : mm_q[g-1];
        f_q[g]   <= f_q[g-1];
        sat_q[g] <= sat_q[g-1];
        shz_q[g] <= shz_q[g-1];
        sh_q[g]  <= sh_q[g-1];
      end
    end
  end

  logic [31:0] p_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (yz_q[NFL-1])      p_q <= ONE;
      else if (xz_q[NFL-1]) p_q <= '0;
      else if (sat_q[FB])   p_q <= ffv_pkg::QMAX;
      else if (shz_q[FB])   p_q <= '0;
      else                  p_q <= mm_q[FB] >> sh_q[FB];
    end
  end

  assign p_o = p_q;

endmodule

[hw/rtl/fractal_floc_viscosity.sv]
// ----------------------------------------------------------------------------
// fractal_floc_viscosity: effective viscosity of a flocculated suspension
// Clamped solid fraction gives yield stress and suspension viscosity; their
// power terms combine into a viscosity capped by a register.
// ----------------------------------------------------------------------------
//   channel | signals                               | direction
//   in      | in_valid_i, in_stall_o, fields        | strain, fraction in
//   out     | out_valid_o, out_stall_i, viscosity_o | viscosity out
//   cfg     | cfg_valid_i, cfg_ready_o, index, data | register write
//
// One cell per cycle while the skid register is empty; the longest path runs
// through four dividers and four power units. Reset clears valid bits and
// registers to defaults. A stalled output fills a skid register; the pipeline
// then holds until it drains, and the input is stalled from a register.
// ----------------------------------------------------------------------------
module fractal_floc_viscosity #(
  parameter int FRAC_BITS = ffv_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] strain_rate_i,
  input  logic [15:0] solid_fraction_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] viscosity_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int D   = ffv_pkg::DIV_LAT;
  localparam int P   = 2 * FRAC_BITS + 4;
  localparam int TOT = 4 * D + 7 + 4 * P;
  localparam logic [31:0] ONE = 32'(1 << FRAC_BITS);

  function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] pr;
    pr = (64'(a) * 64'(b)) >> FRAC_BITS;
    return (pr[63:32] != '0) ? ffv_pkg::QMAX : pr[31:0];
  endfunction

  function automatic logic [31:0] qadd(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = 33'(a) + 33'(b);
    return s[32] ? ffv_pkg::QMAX : s[31:0];
  endfunction

  // configuration
  logic [31:0] nuf_q, m_q, tau0_q, fd_q, cap_q, beta_q;
  logic [15:0] msf_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nuf_q  <= ffv_pkg::RST_FLUID_VISC;
      msf_q  <= ffv_pkg::RST_MAX_FRAC;
      m_q    <= ffv_pkg::RST_STRAIN_EXP;
      tau0_q <= ffv_pkg::RST_YIELD;
      fd_q   <= ffv_pkg::RST_FRACTAL_EXP;
      cap_q  <= ffv_pkg::RST_CAP;
      beta_q <= ffv_pkg::RST_BETA;
    end else if (cfg_valid_i) begin
      case (ffv_pkg::cfg_idx_e'(cfg_index_i))
        ffv_pkg::CFG_FLUID_VISC:  nuf_q  <= cfg_data_i;
        ffv_pkg::CFG_MAX_FRAC:    msf_q  <= cfg_data_i[15:0];
        ffv_pkg::CFG_STRAIN_EXP:  m_q    <= cfg_data_i;
        ffv_pkg::CFG_YIELD:       tau0_q <= cfg_data_i;
        ffv_pkg::CFG_FRACTAL_EXP: fd_q   <= cfg_data_i;
        ffv_pkg::CFG_CAP:         cap_q  <= cfg_data_i;
        ffv_pkg::CFG_BETA:        beta_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline enable: hold everything while the skid register is occupied
  logic skid_valid_q, out_valid_q;
  logic en;
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  logic [TOT:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[TOT-1:0], in_valid_i};
  end

  logic [31:0] s0_q;
  logic [15:0] e0_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= strain_rate_i;
      e0_q <= solid_fraction_i;
    end
  end

  // clamp fraction: upper bound first, then the floor
  logic signed [16:0] upper, ecl;
  always_comb begin
    upper = $signed({1'b0, msf_q}) - $signed(ffv_pkg::MARGIN_FRAC);
    ecl   = $signed({1'b0, e0_q});
    if (ecl > upper) ecl = upper;
    if (ecl < $signed(ffv_pkg::FLOOR_FRAC)) ecl = $signed(ffv_pkg::FLOOR_FRAC);
  end

  logic [31:0] r_w, invd_w, srm_w;
  ffv_div #(.FRAC_BITS(FRAC_BITS)) u_div_r (
    .clk_i, .en_i(en), .a_i({16'b0, ecl[15:0]}), .b_i({16'b0, msf_q}), .q_o(r_w));
  ffv_div #(.FRAC_BITS(FRAC_BITS)) u_div_invd (
    .clk_i, .en_i(en), .a_i(ONE), .b_i(fd_q), .q_o(invd_w));
  ffv_pow #(.FRAC_BITS(FRAC_BITS)) u_pow_s (
    .clk_i, .en_i(en), .x_i(s0_q), .y_i(m_q), .p_o(srm_w));

  // gap to one, never below one LSB
  logic [31:0] r1_q, w_q, wd;
  assign wd = (r_w < ONE) ? ((ONE - r_w == '0) ? 32'd1 : ONE - r_w) : 32'd1;
  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_q <= r_w;
      w_q  <= wd;
    end
  end

  logic [31:0] rw_w, ww_q, nf_w;
  ffv_div #(.FRAC_BITS(FRAC_BITS)) u_div_rw (
    .clk_i, .en_i(en), .a_i(r1_q), .b_i(w_q), .q_o(rw_w));
  always_ff @(posedge clk_i) begin
    if (en) ww_q <= qmul(w_q, w_q);
  end
  ffv_div #(.FRAC_BITS(FRAC_BITS)) u_div_nf (
    .clk_i, .en_i(en), .a_i(nuf_q), .b_i(ww_q), .q_o(nf_w));

  logic [31:0] prw_w, tau_q;
  ffv_pow #(.FRAC_BITS(FRAC_BITS)) u_pow_rw (
    .clk_i, .en_i(en), .x_i(rw_w), .y_i(fd_q), .p_o(prw_w));
  always_ff @(posedge clk_i) begin
    if (en) tau_q <= qmul(tau0_q, prw_w);
  end

  // strain term; floor the strain power at the power of one LSB
  logic [31:0] lo_w, srm_q, bs_q, inv_w;
  ffv_pow #(.FRAC_BITS(FRAC_BITS)) u_pow_lo (
    .clk_i, .en_i(en), .x_i(32'd1), .y_i(m_q), .p_o(lo_w));
  always_ff @(posedge clk_i) begin
    if (en) begin
      srm_q <= (srm_w < lo_w) ? lo_w : srm_w;
      bs_q  <= qmul(beta_q, srm_q);
    end
  end
  ffv_div #(.FRAC_BITS(FRAC_BITS)) u_div_inv (
    .clk_i, .en_i(en), .a_i(ONE), .b_i(bs_q), .q_o(inv_w));

  logic [31:0] nf_tau, tn_w, q_w;
  ffv_dly #(.WIDTH(32), .DEPTH(P)) u_dly_nf (
    .clk_i, .en_i(en), .d_i(nf_w), .q_o(nf_tau));
  ffv_div #(.FRAC_BITS(FRAC_BITS)) u_div_tn (
    .clk_i, .en_i(en), .a_i(tau_q), .b_i(nf_tau), .q_o(tn_w));
  ffv_pow #(.FRAC_BITS(FRAC_BITS)) u_pow_q (
    .clk_i, .en_i(en), .x_i(tn_w), .y_i(m_q), .p_o(q_w));

  logic [31:0] inv_d, iq_q, base_q;
  ffv_dly #(.WIDTH(32), .DEPTH(2 * D + P)) u_dly_inv (
    .clk_i, .en_i(en), .d_i(inv_w), .q_o(inv_d));
  always_ff @(posedge clk_i) begin
    if (en) begin
      iq_q   <= qmul(inv_d, q_w);
      base_q <= qadd(ONE, iq_q);
    end
  end

  logic [31:0] invd_t1, invd_t3, invd_t2;
  ffv_dly #(.WIDTH(32), .DEPTH(D + 2 + P)) u_dly_invd1 (
    .clk_i, .en_i(en), .d_i(invd_w), .q_o(invd_t1));
  ffv_dly #(.WIDTH(32), .DEPTH(D + 3)) u_dly_invd3 (
    .clk_i, .en_i(en), .d_i(invd_w), .q_o(invd_t3));
  ffv_dly #(.WIDTH(32), .DEPTH(2 * D + 4 + 2 * P)) u_dly_invd2 (
    .clk_i, .en_i(en), .d_i(invd_w), .q_o(invd_t2));

  logic [31:0] t1_w, t2_w, t3_w, s_nf, ns_q;
  ffv_pow #(.FRAC_BITS(FRAC_BITS)) u_pow_t1 (
    .clk_i, .en_i(en), .x_i(tau_q), .y_i(invd_t1), .p_o(t1_w));

  ffv_dly #(.WIDTH(32), .DEPTH(2 * D + 2)) u_dly_s1 (
    .clk_i, .en_i(en), .d_i(s0_q), .q_o(s_nf));
  always_ff @(posedge clk_i) begin
    if (en) ns_q <= qmul(nf_w, s_nf);
  end
  ffv_pow #(.FRAC_BITS(FRAC_BITS)) u_pow_t3 (
    .clk_i, .en_i(en), .x_i(ns_q), .y_i(invd_t3), .p_o(t3_w));

  ffv_pow #(.FRAC_BITS(FRAC_BITS)) u_pow_t2 (
    .clk_i, .en_i(en), .x_i(base_q), .y_i(invd_t2), .p_o(t2_w));

  logic [31:0] t3_d, t1_d, tt_q, sum_q;
  ffv_dly #(.WIDTH(32), .DEPTH(D + 1 + 2 * P)) u_dly_t3 (
    .clk_i, .en_i(en), .d_i(t3_w), .q_o(t3_d));
  ffv_dly #(.WIDTH(32), .DEPTH(D + 3 + P)) u_dly_t1 (
    .clk_i, .en_i(en), .d_i(t1_w), .q_o(t1_d));
  always_ff @(posedge clk_i) begin
    if (en) begin
      tt_q  <= qmul(t2_w, t3_d);
      sum_q <= qadd(t1_d, tt_q);
    end
  end

  logic [31:0] pf_w, s_fin, sdiv, vis_w, res_q;
  ffv_pow #(.FRAC_BITS(FRAC_BITS)) u_pow_f (
    .clk_i, .en_i(en), .x_i(sum_q), .y_i(fd_q), .p_o(pf_w));
  ffv_dly #(.WIDTH(32), .DEPTH(3 * D + 6 + 4 * P)) u_dly_s2 (
    .clk_i, .en_i(en), .d_i(s0_q), .q_o(s_fin));
  assign sdiv = (s_fin == '0) ? 32'd1 : s_fin;
  ffv_div #(.FRAC_BITS(FRAC_BITS)) u_div_f (
    .clk_i, .en_i(en), .a_i(pf_w), .b_i(sdiv), .q_o(vis_w));
  always_ff @(posedge clk_i) begin
    if (en) res_q <= (vis_w > cap_q) ? cap_q : vis_w;
  end

  // output register plus skid
  logic [31:0] out_data_q, skid_data_q;
  logic        take;
  assign take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (en) begin
      if (vld_q[TOT]) begin
        if (!out_valid_q || take) out_valid_q <= 1'b1;
        else                      skid_valid_q <= 1'b1;
      end else if (take) begin
        out_valid_q <= 1'b0;
      end
    end else if (take) begin
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (vld_q[TOT]) begin
        if (!out_valid_q || take) out_data_q  <= res_q;
        else                      skid_data_q <= res_q;
      end
    end else if (take) begin
      out_data_q <= skid_data_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign viscosity_o = out_data_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid occupied with empty output register");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid filled without a stalled output beat");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> (out_valid_q && !skid_valid_q))
    else $error("skid beat not moved to output");

  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (viscosity_o <= cap_q))
    else $error("viscosity above cap");

endmodule

[tb/sv/ffv_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ffv_checker: viscosity predictor and scoreboard
// Watches the cell, result and register channels at the rising edge, works
// out the viscosity of every accepted cell and compares it with the result.
// ----------------------------------------------------------------------------
module ffv_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] strain_rate_i,
  input  logic [15:0] solid_fraction_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] viscosity_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o,
  output int          cells_o
);

  typedef longint unsigned u64_t;
  typedef longint          s64_t;

  localparam int   FB   = ffv_pkg::FRAC_BITS_DEF;
  localparam u64_t ONE  = u64_t'(1) << FB;
  localparam u64_t TOP  = 64'hFFFF_FFFF;

  logic [31:0] nuf, tau0, m_exp, d_exp, cap, beta;
  logic [15:0] emax;
  u64_t        roots [1:24];
  logic [31:0] visc_expected [$];

  function automatic u64_t int_sqrt(input u64_t v);
    u64_t res, bm;
    res = 0;
    bm  = u64_t'(1) << 62;
    while (bm > v) bm = bm >> 2;
    while (bm != 0) begin
      if (v >= res + bm) begin
        v   = v - (res + bm);
        res = (res >> 1) + bm;
      end else begin
        res = res >> 1;
      end
      bm = bm >> 2;
    end
    return res;
  endfunction

  function automatic u64_t clip(input u64_t v);
    return (v > TOP) ? TOP : v;
  endfunction

  function automatic u64_t fx_mul(input u64_t a, input u64_t b);
    return clip((a * b) >> FB);
  endfunction

  function automatic u64_t fx_div(input u64_t a, input u64_t b);
    if (b == 0) return (a == 0) ? 0 : TOP;
    return clip((a << FB) / b);
  endfunction

  function automatic s64_t floor_q(input s64_t p);
    if (p >= 0) return p >>> FB;
    return -s64_t'((u64_t'(-p) + (ONE - 1)) >> FB);
  endfunction

  function automatic s64_t fx_log2(input u64_t x);
    int   p;
    u64_t z, frac;
    p    = 31;
    frac = 0;
    while (p > 0 && x[p] == 1'b0) p--;
    z = x << (31 - p);
    for (int i = 1; i <= FB; i++) begin
      z = (z * z) >> 31;
      if (z >= (u64_t'(1) << 32)) begin
        z    = z >> 1;
        frac = frac | (u64_t'(1) << (FB - i));
      end
    end
    return s64_t'(p) * s64_t'(ONE) - s64_t'(FB) * s64_t'(ONE) + s64_t'(frac);
  endfunction

  function automatic u64_t fx_exp2(input s64_t t);
    s64_t k, sh;
    u64_t f, mant;
    mant = u64_t'(1) << 31;
    if (t >= s64_t'(32 - FB) * s64_t'(ONE)) return TOP;
    k = floor_q(t);
    f = u64_t'(t) & (ONE - 1);
    for (int i = 1; i <= FB; i++)
      if (f[FB - i]) mant = (mant * roots[i]) >> 31;
    sh = k + FB - 31;
    if (sh >= 0) return clip(mant);
    if (-sh >= 40) return 0;
    return clip(mant >> (-sh));
  endfunction

  function automatic u64_t fx_pow(input u64_t x, input u64_t y);
    if (y == 0) return ONE;
    if (x == 0) return 0;
    return fx_exp2(floor_q(fx_log2(x) * s64_t'(y)));
  endfunction

  function automatic logic [31:0] cell_viscosity(input u64_t s, input logic [15:0] frac);
    s64_t e, upper;
    u64_t r, w, tau, nf, invd, srm, lo, inv, q, base, t1, t2, t3, sum, res;
    e     = s64_t'(frac);
    upper = s64_t'(emax) - s64_t'(ffv_pkg::MARGIN_FRAC);
    if (e > upper) e = upper;
    if (e < s64_t'(ffv_pkg::FLOOR_FRAC)) e = s64_t'(ffv_pkg::FLOOR_FRAC);
    if (emax == 0) r = TOP;
    else r = clip((u64_t'(e) << FB) / u64_t'(emax));
    w = (r < ONE) ? ONE - r : 0;
    if (w < 1) w = 1;
    tau  = fx_mul(tau0, fx_pow(fx_div(r, w), d_exp));
    nf   = fx_div(nuf, fx_mul(w, w));
    invd = fx_div(ONE, d_exp);
    srm  = fx_pow(s, m_exp);
    lo   = fx_pow(1, m_exp);
    if (srm < lo) srm = lo;
    inv  = fx_div(ONE, fx_mul(beta, srm));
    q    = fx_pow(fx_div(tau, nf), m_exp);
    base = clip(ONE + fx_mul(inv, q));
    t1   = fx_pow(tau, invd);
    t2   = fx_pow(base, invd);
    t3   = fx_pow(fx_mul(nf, s), invd);
    sum  = clip(t1 + fx_mul(t2, t3));
    res  = fx_div(fx_pow(sum, d_exp), (s == 0) ? 1 : s);
    if (res > cap) res = cap;
    return res[31:0];
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o  = 0;
    cells_o   = 0;
    roots[1]  = int_sqrt(u64_t'(1) << 63);
    for (int i = 2; i <= 24; i++) roots[i] = int_sqrt(roots[i - 1] << 31);
  end

  assign pending_o = visc_expected.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nuf   <= ffv_pkg::RST_FLUID_VISC;
      emax  <= ffv_pkg::RST_MAX_FRAC;
      m_exp <= ffv_pkg::RST_STRAIN_EXP;
      tau0  <= ffv_pkg::RST_YIELD;
      d_exp <= ffv_pkg::RST_FRACTAL_EXP;
      cap   <= ffv_pkg::RST_CAP;
      beta  <= ffv_pkg::RST_BETA;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (ffv_pkg::cfg_idx_e'(cfg_index_i))
          ffv_pkg::CFG_FLUID_VISC:  nuf   <= cfg_data_i;
          ffv_pkg::CFG_MAX_FRAC:    emax  <= cfg_data_i[15:0];
          ffv_pkg::CFG_STRAIN_EXP:  m_exp <= cfg_data_i;
          ffv_pkg::CFG_YIELD:       tau0  <= cfg_data_i;
          ffv_pkg::CFG_FRACTAL_EXP: d_exp <= cfg_data_i;
          ffv_pkg::CFG_CAP:         cap   <= cfg_data_i;
          ffv_pkg::CFG_BETA:        beta  <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        visc_expected.push_back(cell_viscosity(strain_rate_i, solid_fraction_i));
        cells_o++;
      end
      if (out_valid_i && !out_stall_i) begin
        if (visc_expected.size() == 0) begin
          report("unexpected beat", viscosity_i, '0);
        end else begin
          if (viscosity_i !== visc_expected[0])
            report("viscosity", viscosity_i, visc_expected[0]);
          void'(visc_expected.pop_front());
        end
      end
    end
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: floc viscosity block
// Streams directed and random cells through several register settings with
// random gaps and stalls on both sides; the checker predicts every result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SETTLE = 320;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [31:0] strain = '0;
  logic [15:0] frac = '0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_stall, out_valid, cfg_ready;
  logic [31:0] viscosity;
  int          errors, pending, cells;
  int          send_idle, recv_idle;
  logic        hold_req = 1'b0;
  int          hold_cnt = 0;

  always #6 clk = ~clk;

  fractal_floc_viscosity u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .strain_rate_i(strain), .solid_fraction_i(frac),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .viscosity_o(viscosity),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  ffv_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .strain_rate_i(strain), .solid_fraction_i(frac),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .viscosity_i(viscosity),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending), .cells_o(cells)
  );

  // receiver: random stall, or a long counted hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt  <= 400;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_cell(input logic [31:0] s, input logic [15:0] f);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    strain   <= s;
    frac     <= f;
    #1;
    while (in_stall) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
  endtask

  // leaves valid high; the caller drops it after the last beat
  task automatic write_reg(input ffv_pkg::cfg_idx_e idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    #1;
    while (!cfg_ready) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic load_setting(input logic [31:0] nuf, input logic [15:0] emax,
                              input logic [31:0] m, input logic [31:0] tau,
                              input logic [31:0] d, input logic [31:0] cap,
                              input logic [31:0] beta);
    drain();
    write_reg(ffv_pkg::CFG_FLUID_VISC, nuf);
    write_reg(ffv_pkg::CFG_MAX_FRAC, {16'h0, emax});
    write_reg(ffv_pkg::CFG_STRAIN_EXP, m);
    write_reg(ffv_pkg::CFG_YIELD, tau);
    write_reg(ffv_pkg::CFG_FRACTAL_EXP, d);
    write_reg(ffv_pkg::CFG_CAP, cap);
    write_reg(ffv_pkg::CFG_BETA, beta);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_strain();
    case ($urandom_range(3))
      0: return $urandom_range(3);
      1: return $urandom >> $urandom_range(31);
      2: return $urandom_range(32'h0003_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_cells(input int n);
    for (int i = 0; i < n; i++) send_cell(rand_strain(), 16'($urandom));
  endtask

  initial begin
    send_idle = 0;
    recv_idle = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: field extremes, clamp edges, zero strain
    send_cell(32'h0, 16'h0);
    send_cell(32'hFFFF_FFFF, 16'hFFFF);
    send_cell(32'h1, 16'd19661);
    send_cell(32'h0001_0000, 16'd19660);
    send_cell(32'h0001_0000, 16'd38667);
    send_cell(32'h0001_0000, 16'd38668);
    send_cell(32'h8000_0000, 16'h8000);
    send_cell(32'h0000_FFFF, 16'h7FFF);
    send_cell(32'h5555_5555, 16'hAAAA);
    send_cell(32'hAAAA_AAAA, 16'h5555);
    // cap below clamp floor, zero max fraction, saturated ratio
    load_setting(32'h0, 16'd0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h1);
    send_cell(32'h0, 16'h0);
    send_cell(32'hFFFF_FFFF, 16'hFFFF);
    send_cell(32'h0002_0000, 16'h4000);
    load_setting(32'hFFFF_FFFF, 16'd20000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cell(32'h0, 16'h0);
    send_cell(32'hFFFF_FFFF, 16'hFFFF);
    send_cell(32'h0000_8000, 16'd20000);
    load_setting(ffv_pkg::RST_FLUID_VISC, 16'hFFFF, 32'h0000_8000, 32'h0002_0000,
                 32'h0000_C000, 32'h0100_0000, 32'h0000_4000);
    send_cell(32'h0, 16'hFFFF);
    send_cell(32'h0000_0100, 16'd65000);
    send_cell(32'h0010_0000, 16'd30000);

    // random phases: receiver-heavy idle, sender-heavy idle, none
    send_idle = 33; recv_idle = 70;
    load_setting(ffv_pkg::RST_FLUID_VISC, ffv_pkg::RST_MAX_FRAC, ffv_pkg::RST_STRAIN_EXP,
                 ffv_pkg::RST_YIELD, ffv_pkg::RST_FRACTAL_EXP, ffv_pkg::RST_CAP,
                 ffv_pkg::RST_BETA);
    random_cells(100);
    // fill the pipe against a long hold-off until the input stalls
    send_idle = 0;
    in_valid <= 1'b0;
    hold_req <= 1'b1;
    @(negedge clk);
    hold_req <= 1'b0;
    random_cells(300);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    random_cells(20);

    send_idle = 70; recv_idle = 33;
    load_setting($urandom >> 8, 16'($urandom_range(20000, 65535)), $urandom >> 14,
                 $urandom >> 12, $urandom_range(32'h0000_4000, 32'h0004_0000),
                 $urandom, $urandom_range(1, 32'h0010_0000));
    random_cells(80);

    send_idle = 0; recv_idle = 0;
    load_setting($urandom, 16'($urandom), $urandom, $urandom, $urandom_range(1, 32'hFFFF_FFFF),
                 $urandom, $urandom_range(1, 32'hFFFF_FFFF));
    random_cells(50);
    load_setting($urandom >> 12, 16'($urandom_range(30000, 50000)), 32'h0001_0000,
                 $urandom >> 10, 32'h0001_8000, 32'hFFFF_FFFF, 32'h0001_0000);
    random_cells(30);

    drain();
    $display("Ran %0d cells over seven register settings with gaps, stalls and a long hold-off.",
             cells);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
